// ===== hdl/fla_pkg.sv =====
package fla_pkg;

  localparam int MAX_REGIONS = 1024;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_REGIONS);

  localparam logic [31:0] PAGE_LOW  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_HIGH = 32'hffff_f000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // datapath operations
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_READ       = 5'd2;
  localparam logic [4:0] OP_READ_BELOW = 5'd3;
  localparam logic [4:0] OP_NEXT       = 5'd4;
  localparam logic [4:0] OP_NOFIT      = 5'd5;
  localparam logic [4:0] OP_TAKE       = 5'd6;
  localparam logic [4:0] OP_DEC_COUNT  = 5'd7;
  localparam logic [4:0] OP_WRITE_DOWN = 5'd8;
  localparam logic [4:0] OP_SAVE_PREV  = 5'd9;
  localparam logic [4:0] OP_MERGE_PREV = 5'd10;
  localparam logic [4:0] OP_MERGE_NEXT = 5'd11;
  localparam logic [4:0] OP_MARK       = 5'd12;
  localparam logic [4:0] OP_INSERT     = 5'd13;
  localparam logic [4:0] OP_WRITE_UP   = 5'd14;
  localparam logic [4:0] OP_LOST       = 5'd15;
  localparam logic [4:0] OP_SUM_INIT   = 5'd16;
  localparam logic [4:0] OP_ACC        = 5'd17;
  localparam logic [4:0] OP_FINISH     = 5'd18;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic at_end;      // index reached entry count
    logic fits;        // read length >= size
    logic exact;       // read length == size
    logic beyond;      // read start > address
    logic prev_merge;
    logic next_merge;
    logic has_room;
    logic at_mark;     // shift-up index reached insert point
    logic out_busy;
  } dp_stat_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

// ===== hdl/fla_req_if.sv =====
interface fla_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] block_address;
  logic [31:0] block_size;
  logic        round_to_page;

  modport source (output valid, command, block_address, block_size, round_to_page,
                  input ready);
  modport sink   (input valid, command, block_address, block_size, round_to_page,
                  output ready);
endinterface

// ===== hdl/fla_rsp_if.sv =====
interface fla_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [31:0] free_bytes;
  logic [10:0] entry_count;
  logic [10:0] peak_entries;
  logic [31:0] lost_count;
  logic [31:0] lost_bytes;

  modport source (output valid, granted_address, status, free_bytes, entry_count,
                  peak_entries, lost_count, lost_bytes, input ready);
  modport sink   (input valid, granted_address, status, free_bytes, entry_count,
                  peak_entries, lost_count, lost_bytes, output ready);
endinterface

// ===== hdl/fla_ctrl.sv =====
module fla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fla_pkg::dp_stat_t stat,
  output fla_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_A_CHECK  = 4'd2;
  localparam logic [3:0] S_A_EVAL   = 4'd3;
  localparam logic [3:0] S_SL_CHECK = 4'd4;
  localparam logic [3:0] S_SL_WRITE = 4'd5;
  localparam logic [3:0] S_F_CHECK  = 4'd6;
  localparam logic [3:0] S_F_EVAL   = 4'd7;
  localparam logic [3:0] S_F_DECIDE = 4'd8;
  localparam logic [3:0] S_SR_CHECK = 4'd9;
  localparam logic [3:0] S_SR_WRITE = 4'd10;
  localparam logic [3:0] S_SUM_INIT = 4'd11;
  localparam logic [3:0] S_SUM_CHK  = 4'd12;
  localparam logic [3:0] S_SUM_ACC  = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = fla_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = fla_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_free)       state_next = S_A_CHECK;
        else if (stat.size_zero) state_next = S_SUM_INIT;
        else                     state_next = S_F_CHECK;
      end
      S_A_CHECK: begin
        if (stat.at_end) begin
          cmd.op     = fla_pkg::OP_NOFIT;
          state_next = S_SUM_INIT;
        end else begin
          cmd.op     = fla_pkg::OP_READ;
          state_next = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (stat.fits) begin
          cmd.op     = fla_pkg::OP_TAKE;
          state_next = stat.exact ? S_SL_CHECK : S_SUM_INIT;
        end else begin
          cmd.op     = fla_pkg::OP_NEXT;
          state_next = S_A_CHECK;
        end
      end
      S_SL_CHECK: begin
        if (stat.at_end) begin
          cmd.op     = fla_pkg::OP_DEC_COUNT;
          state_next = S_SUM_INIT;
        end else begin
          cmd.op     = fla_pkg::OP_READ;
          state_next = S_SL_WRITE;
        end
      end
      S_SL_WRITE: begin
        cmd.op     = fla_pkg::OP_WRITE_DOWN;
        state_next = S_SL_CHECK;
      end
      S_F_CHECK: begin
        if (stat.at_end) begin
          state_next = S_F_DECIDE;
        end else begin
          cmd.op     = fla_pkg::OP_READ;
          state_next = S_F_EVAL;
        end
      end
      S_F_EVAL: begin
        if (stat.beyond) begin
          state_next = S_F_DECIDE;
        end else begin
          cmd.op     = fla_pkg::OP_SAVE_PREV;
          state_next = S_F_CHECK;
        end
      end
      S_F_DECIDE: begin
        if (stat.prev_merge) begin
          cmd.op     = fla_pkg::OP_MERGE_PREV;
          state_next = stat.next_merge ? S_SL_CHECK : S_SUM_INIT;
        end else if (stat.next_merge) begin
          cmd.op     = fla_pkg::OP_MERGE_NEXT;
          state_next = S_SUM_INIT;
        end else if (stat.has_room) begin
          cmd.op     = fla_pkg::OP_MARK;
          state_next = S_SR_CHECK;
        end else begin
          cmd.op     = fla_pkg::OP_LOST;
          state_next = S_SUM_INIT;
        end
      end
      S_SR_CHECK: begin
        if (stat.at_mark) begin
          cmd.op     = fla_pkg::OP_INSERT;
          state_next = S_SUM_INIT;
        end else begin
          cmd.op     = fla_pkg::OP_READ_BELOW;
          state_next = S_SR_WRITE;
        end
      end
      S_SR_WRITE: begin
        cmd.op     = fla_pkg::OP_WRITE_UP;
        state_next = S_SR_CHECK;
      end
      S_SUM_INIT: begin
        cmd.op     = fla_pkg::OP_SUM_INIT;
        state_next = S_SUM_CHK;
      end
      S_SUM_CHK: begin
        if (stat.at_end) begin
          if (!stat.out_busy) begin
            cmd.op     = fla_pkg::OP_FINISH;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = fla_pkg::OP_READ;
          state_next = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        cmd.op     = fla_pkg::OP_ACC;
        state_next = S_SUM_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/fla_datapath.sv =====
module fla_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  fla_pkg::dp_cmd_t            cmd,
  output fla_pkg::dp_stat_t           stat,
  input  logic                        command,
  input  logic [31:0]                 block_address,
  input  logic [31:0]                 block_size,
  input  logic                        round_to_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 granted_address,
  output logic [1:0]                  status,
  output logic [31:0]                 free_bytes,
  output logic [fla_pkg::CNT_W-1:0]   entry_count,
  output logic [fla_pkg::CNT_W-1:0]   peak_entries,
  output logic [31:0]                 lost_count,
  output logic [31:0]                 lost_bytes
);

  logic [63:0] mem [fla_pkg::MAX_REGIONS];

  logic                      op_free;
  logic [31:0]               addr, size;
  logic [fla_pkg::CNT_W-1:0] idx, kpos, count, peak;
  logic [31:0]               rd_s, rd_l, prev_s, prev_l;
  logic                      prev_valid;
  logic [31:0]               sum, granted, lost_cnt, lost_b;
  logic [1:0]                st;

  logic [fla_pkg::CNT_W-1:0] idx_dec;
  logic [32:0]               end33, prev_end;
  logic [31:0]               size_in, prev_plus, both_len;
  logic                      we;
  logic [fla_pkg::IDX_W-1:0] waddr, raddr;
  logic [63:0]               wdata;

  assign idx_dec   = idx - 1'b1;
  assign end33     = {1'b0, addr} + {1'b0, size};
  assign prev_end  = {1'b0, prev_s} + {1'b0, prev_l};
  assign prev_plus = fla_pkg::sat_add(prev_l, size);
  assign both_len  = fla_pkg::sat_add(prev_plus, rd_l);
  assign size_in   = round_to_page ? ((block_size + fla_pkg::PAGE_LOW) & fla_pkg::PAGE_HIGH)
                                   : block_size;

  always_comb begin
    stat.is_free    = op_free;
    stat.size_zero  = (size == 32'd0);
    stat.at_end     = (idx == count);
    stat.fits       = (rd_l >= size);
    stat.exact      = (rd_l == size);
    stat.beyond     = (rd_s > addr);
    stat.prev_merge = prev_valid && (prev_end == {1'b0, addr});
    stat.next_merge = (idx != count) && (end33 == {1'b0, rd_s});
    stat.has_room   = (count < fla_pkg::MAX_COUNT);
    stat.at_mark    = (idx == kpos);
    stat.out_busy   = out_valid && !out_ready;
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = idx[fla_pkg::IDX_W-1:0];
    wdata = {rd_s, rd_l};
    case (cmd.op)
      fla_pkg::OP_TAKE: begin
        we    = (rd_l != size);
        wdata = {rd_s + size, rd_l - size};
      end
      fla_pkg::OP_WRITE_DOWN: begin
        we    = 1'b1;
        waddr = idx_dec[fla_pkg::IDX_W-1:0];
      end
      fla_pkg::OP_MERGE_PREV: begin
        we    = 1'b1;
        waddr = idx_dec[fla_pkg::IDX_W-1:0];
        wdata = {prev_s, stat.next_merge ? both_len : prev_plus};
      end
      fla_pkg::OP_MERGE_NEXT: begin
        we    = 1'b1;
        wdata = {addr, fla_pkg::sat_add(rd_l, size)};
      end
      fla_pkg::OP_INSERT: begin
        we    = 1'b1;
        waddr = kpos[fla_pkg::IDX_W-1:0];
        wdata = {addr, size};
      end
      fla_pkg::OP_WRITE_UP: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  assign raddr = (cmd.op == fla_pkg::OP_READ_BELOW) ? idx_dec[fla_pkg::IDX_W-1:0]
                                                    : idx[fla_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.op == fla_pkg::OP_READ || cmd.op == fla_pkg::OP_READ_BELOW)
      {rd_s, rd_l} <= mem[raddr];
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      fla_pkg::OP_LOAD: begin
        op_free    <= (command == fla_pkg::CMD_FREE);
        addr       <= block_address;
        size       <= size_in;
        idx        <= '0;
        prev_valid <= 1'b0;
        granted    <= 32'd0;
        st         <= fla_pkg::ST_OK;
      end
      fla_pkg::OP_NEXT:       idx <= idx + 1'b1;
      fla_pkg::OP_NOFIT:      st  <= fla_pkg::ST_NOFIT;
      fla_pkg::OP_TAKE: begin
        granted <= rd_s;
        if (rd_l == size) idx <= idx + 1'b1;
      end
      fla_pkg::OP_WRITE_DOWN: idx <= idx + 1'b1;
      fla_pkg::OP_SAVE_PREV: begin
        prev_s     <= rd_s;
        prev_l     <= rd_l;
        prev_valid <= 1'b1;
        idx        <= idx + 1'b1;
      end
      fla_pkg::OP_MERGE_PREV: if (stat.next_merge) idx <= idx + 1'b1;
      fla_pkg::OP_MARK: begin
        kpos <= idx;
        idx  <= count;
      end
      fla_pkg::OP_WRITE_UP:   idx <= idx_dec;
      fla_pkg::OP_LOST:       st  <= fla_pkg::ST_LOST;
      fla_pkg::OP_SUM_INIT: begin
        idx <= '0;
        sum <= 32'd0;
      end
      fla_pkg::OP_ACC: begin
        sum <= fla_pkg::sat_add(sum, rd_l);
        idx <= idx + 1'b1;
      end
      default: ;
    endcase
  end

  // table statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      peak     <= '0;
      lost_cnt <= 32'd0;
      lost_b   <= 32'd0;
    end else begin
      case (cmd.op)
        fla_pkg::OP_DEC_COUNT: count <= count - 1'b1;
        fla_pkg::OP_INSERT: begin
          count <= count + 1'b1;
          if (peak < count + 1'b1) peak <= count + 1'b1;
        end
        fla_pkg::OP_LOST: begin
          lost_cnt <= fla_pkg::sat_add(lost_cnt, 32'd1);
          lost_b   <= fla_pkg::sat_add(lost_b, size);
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.op == fla_pkg::OP_FINISH) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == fla_pkg::OP_FINISH) begin
      granted_address <= granted;
      status          <= st;
      free_bytes      <= sum;
      entry_count     <= count;
      peak_entries    <= peak;
      lost_count      <= lost_cnt;
      lost_bytes      <= lost_b;
    end
  end

endmodule

// ===== hdl/free_list_allocator.sv =====
// Sequence: a search pass over the N entries held, an entry shift where
//   needed, then a free-byte sum pass over all N entries in the table.
// Throughput: one transaction at a time; the single-port region table, with
//   one access per cycle, sets the pace. A new request is taken while
//   the previous result still waits in the output register.
// Reset: rst clears counters, statistics and handshake state; table contents
//   are not cleared, since only entries below the entry count are read.
module free_list_allocator (
  input  logic clk,
  input  logic rst,
  fla_req_if.sink   req,
  fla_rsp_if.source rsp
);

  fla_pkg::dp_cmd_t  cmd;
  fla_pkg::dp_stat_t stat;

  // controller: sequences search, shift and sum passes over the table
  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: region table, working registers, statistics, result register
  fla_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (req.command),
    .block_address   (req.block_address),
    .block_size      (req.block_size),
    .round_to_page   (req.round_to_page),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .granted_address (rsp.granted_address),
    .status          (rsp.status),
    .free_bytes      (rsp.free_bytes),
    .entry_count     (rsp.entry_count),
    .peak_entries    (rsp.peak_entries),
    .lost_count      (rsp.lost_count),
    .lost_bytes      (rsp.lost_bytes)
  );

`ifndef SYNTHESIS
  // a request is worked on alone: no second transaction right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.entry_count <= rsp.peak_entries)
    else $error("entry count above peak");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == fla_pkg::ST_NOFIT || rsp.status == fla_pkg::ST_LOST)
      |-> rsp.granted_address == 32'd0)
    else $error("address granted on failure");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status != 2'd3)
    else $error("undefined status code");
`endif

endmodule
